[hdl/lrrd_pkg.sv]
package lrrd_pkg;

	localparam int WordW   = 32;
	localparam int RawW    = 15;
	localparam int RawLsb  = 16;
	localparam int MulBits = 18;
	localparam int DivW    = RawW + 1;

	localparam logic [MulBits-1:0] LcgMul  = 18'd214013;
	localparam logic [WordW-1:0]   LcgAdd  = 32'd2531011;
	localparam logic [WordW-1:0]   LcgSeed = 32'd1;

	// divisor used when the span reaches past the raw range: keeps raw as is
	localparam logic [DivW-1:0] DivFull = 16'h8000;

	localparam logic OpReseed = 1'b0;
	localparam logic OpDraw   = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
	} lrrd_lcg_ctl_t;

endpackage

[hdl/lrrd_lcg.sv]
module lrrd_lcg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrrd_pkg::lrrd_lcg_ctl_t       ctl,
	input  logic [lrrd_pkg::WordW-1:0]    seed,
	output logic [lrrd_pkg::WordW-1:0]    state,
	output logic                          done
);
	import lrrd_pkg::*;

	localparam int CntW = $clog2(MulBits);

	logic [WordW-1:0]   state_q;
	logic [WordW-1:0]   mcand_q;
	logic [WordW-1:0]   acc_q;
	logic [WordW-1:0]   acc_next;
	logic [MulBits-1:0] mplier_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               last;

	// one multiplier bit per cycle, lsb first
	assign acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign last     = (cnt_q == CntW'(MulBits - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LcgSeed;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				state_q <= seed;
			end else if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (last) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= acc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= state_q;
			mplier_q <= LcgMul;
			acc_q    <= LcgAdd;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			mcand_q  <= {mcand_q[WordW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MulBits-1:1]};
		end
	end

	assign state = state_q;
	assign done  = done_q;

endmodule

[hdl/lrrd_mod.sv]
module lrrd_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lrrd_pkg::RawW-1:0]    dividend,
	input  logic [lrrd_pkg::DivW-1:0]    divisor,
	output logic [lrrd_pkg::RawW-1:0]    remainder,
	output logic                         done
);
	import lrrd_pkg::*;

	localparam int CntW = $clog2(RawW);

	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] div_q;
	logic [RawW-1:0] dvd_q;
	logic [DivW-1:0] trial;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	// restoring step: bring in the next dividend bit, subtract if it fits
	assign trial = {rem_q[DivW-2:0], dvd_q[RawW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(RawW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= (trial >= div_q) ? (trial - div_q) : trial;
			dvd_q <= {dvd_q[RawW-2:0], 1'b0};
		end
	end

	assign remainder = rem_q[RawW-1:0];
	assign done      = done_q;

endmodule

[hdl/lcg_ranged_random_draw.sv]
// Ranged random draw from a 32-bit linear congruential generator
// (state = state * 214013 + 2531011, reset state 1). A reseed transaction
// (op 0) loads the state in the cycle it is accepted and returns nothing.
// A draw transaction (op 1) orders min/max into lo/hi, advances the state
// and returns lo + (state bits 30..16) mod (hi - lo + 1); a span above
// 2^31-1 returns zero with span_error set and leaves the state alone. A
// draw goes from acceptance through the span check, the bit-serial
// constant multiply of the generator and the restoring remainder of the
// 15-bit raw value to the final add; a draw with a span error skips the
// multiply and the remainder. in_stall stays high while a draw is in
// flight; the result sits in an output register, so the next transaction
// is accepted while a finished result still waits on out_stall.
module lcg_ranged_random_draw (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic [lrrd_pkg::WordW-1:0]         seed_value,
	input  logic signed [lrrd_pkg::WordW-1:0]  min_value,
	input  logic signed [lrrd_pkg::WordW-1:0]  max_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lrrd_pkg::WordW-1:0]  number,
	output logic                               span_error
);
	import lrrd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SPAN = 5'b00010,
		ST_LCG  = 5'b00100,
		ST_MOD  = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t state_q;

	// draw operands, held for the whole transaction
	logic signed [WordW-1:0] lo_q;
	logic signed [WordW-1:0] hi_q;
	logic [DivW-1:0]         div_q;
	logic                    err_q;

	// output register
	logic                    out_valid_q;
	logic signed [WordW-1:0] number_q;
	logic                    span_error_q;

	logic                    in_acc;
	logic                    out_free;
	logic [WordW-1:0]        span;
	logic                    span_wide;

	lrrd_lcg_ctl_t           lcg_ctl;
	logic [WordW-1:0]        lcg_state;
	logic                    lcg_done;
	logic                    mod_start;
	logic [RawW-1:0]         mod_rem;
	logic                    mod_done;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// unsigned distance between the ordered bounds
	assign span = hi_q - lo_q;
	// span at or above the raw range: remainder leaves raw unchanged
	assign span_wide = (|span[WordW-2:RawW]) || (&span[RawW-1:0]);

	// generator load on reseed, serial step once the span checks out
	assign lcg_ctl.load  = in_acc && (op == OpReseed);
	assign lcg_ctl.start = (state_q == ST_SPAN) && !span[WordW-1];

	// raw value is taken the cycle the new state lands
	assign mod_start = (state_q == ST_LCG) && lcg_done;

	lrrd_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lcg_ctl),
		.seed   (seed_value),
		.state  (lcg_state),
		.done   (lcg_done)
	);

	lrrd_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (lcg_state[RawLsb +: RawW]),
		.divisor   (div_q),
		.remainder (mod_rem),
		.done      (mod_done)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (op == OpDraw)) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					err_q <= span[WordW-1];
					if (span[WordW-1]) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LCG;
					end
				end
				ST_LCG: begin
					if (lcg_done) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// bounds ordered on acceptance, divisor formed from the span
	always_ff @(posedge clk) begin
		if (in_acc && (op == OpDraw)) begin
			if (max_value < min_value) begin
				lo_q <= max_value;
				hi_q <= min_value;
			end else begin
				lo_q <= min_value;
				hi_q <= max_value;
			end
		end
		if (state_q == ST_SPAN) begin
			div_q <= span_wide ? DivFull : ({1'b0, span[RawW-1:0]} + DivW'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			span_error_q <= err_q;
			if (err_q) begin
				number_q <= '0;
			end else begin
				number_q <= lo_q + $signed({{(WordW - RawW){1'b0}}, mod_rem});
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign number     = number_q;
	assign span_error = span_error_q;

endmodule

[tb/sv/lcg_ranged_random_draw_tb.sv]
module lcg_ranged_random_draw_tb;

	import lrrd_pkg::*;

	// run shape
	localparam int RandomItems = 650;
	localparam int DirectedRows = 22;
	localparam int TotalItems = DirectedRows + RandomItems;
	localparam int CalmTail = 60;        // no idling on either side near the end
	localparam int HoldAt = 300;         // transaction count that triggers the long hold
	localparam int HoldCycles = 240;
	localparam int DrainCycles = 60;
	localparam int IdleLimit = 4000;     // cycles with no transaction on either side

	localparam logic signed [WordW-1:0] MinInt = 32'sh8000_0000;
	localparam logic signed [WordW-1:0] MaxInt = 32'sh7FFF_FFFF;

	// generator constants, kept apart from the block's own copies
	localparam logic [WordW-1:0] GenMul = 32'd214013;
	localparam logic [WordW-1:0] GenAdd = 32'd2531011;
	localparam logic [WordW-1:0] GenSeed = 32'd1;
	localparam logic [WordW-1:0] SpanMax = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [WordW-1:0] number;
		logic                    span_error;
	} draw_result_t;

	// one stimulus row; pinned rows carry an expectation typed in by hand
	typedef struct packed {
		logic                    op;
		logic [WordW-1:0]        seed;
		logic signed [WordW-1:0] lo_bound;
		logic signed [WordW-1:0] hi_bound;
		logic                    pinned;
		logic signed [WordW-1:0] pin_number;
		logic                    pin_error;
	} stim_row_t;

	localparam stim_row_t DirectedTable [DirectedRows] = '{
		// first draw after reset from state 1
		'{OpDraw,   32'h0000_0000, 32'sd0,       32'sd32767,    1'b1, 32'sd41, 1'b0},
		// equal bounds still advance the state
		'{OpDraw,   32'h0000_0000, 32'sd5,       32'sd5,        1'b1, 32'sd5,  1'b0},
		// span too wide, both orders, and just past the limit
		'{OpDraw,   32'hFFFF_FFFF, MinInt,       MaxInt,        1'b1, 32'sd0,  1'b1},
		'{OpDraw,   32'h0000_0000, MaxInt,       MinInt,        1'b1, 32'sd0,  1'b1},
		'{OpDraw,   32'h0000_0000, -32'sd1,      MaxInt,        1'b1, 32'sd0,  1'b1},
		'{OpDraw,   32'h0000_0000, MinInt,       32'sd0,        1'b1, 32'sd0,  1'b1},
		// span exactly at the limit: raw value added unreduced
		'{OpDraw,   32'h0000_0000, 32'sd0,       MaxInt,        1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'h0000_0000, MinInt,       -32'sd1,       1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'h0000_0000, -32'sd1,      32'sh7FFF_FFFE, 1'b0, 32'sd0, 1'b0},
		// reversed bounds
		'{OpDraw,   32'h0000_0000, 32'sd100,     -32'sd100,     1'b0, 32'sd0,  1'b0},
		// reseed to zero, then a small draw
		'{OpReseed, 32'h0000_0000, 32'sd0,       32'sd0,        1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'h0000_0000, 32'sd0,       32'sd9,        1'b0, 32'sd0,  1'b0},
		// reseed to all ones, bounds ignored
		'{OpReseed, 32'hFFFF_FFFF, -32'sd1,      -32'sd1,       1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'hFFFF_FFFF, MinInt,       MinInt,        1'b1, MinInt,  1'b0},
		'{OpDraw,   32'h0000_0000, MaxInt,       MaxInt,        1'b1, MaxInt,  1'b0},
		'{OpDraw,   32'hFFFF_FFFF, 32'sd1,       32'sd0,        1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'h0000_0000, -32'sd1,      32'sd1,        1'b0, 32'sd0,  1'b0},
		'{OpReseed, 32'h8000_0000, MaxInt,       MinInt,        1'b0, 32'sd0,  1'b0},
		// divisor just past the raw range
		'{OpDraw,   32'h0000_0000, 32'sd0,       32'sd32768,    1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'h0000_0000, 32'sd1,       MaxInt,        1'b0, 32'sd0,  1'b0},
		'{OpReseed, 32'h7FFF_FFFF, 32'sd0,       32'sd0,        1'b0, 32'sd0,  1'b0},
		'{OpDraw,   32'hA5A5_A5A5, -32'sd7,      32'sd12,       1'b0, 32'sd0,  1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OpReseed;
	logic [WordW-1:0] seed_value = '0;
	logic signed [WordW-1:0] min_value = '0;
	logic signed [WordW-1:0] max_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [WordW-1:0] number;
	logic span_error;

	// hand-typed expectation travelling with the payload
	logic pin_on = 1'b0;
	logic signed [WordW-1:0] pin_number = '0;
	logic pin_error = 1'b0;

	logic [WordW-1:0] gen_state = GenSeed;  // predictor's copy of the generator
	draw_result_t expected_draws [$];
	int n_errors = 0;
	int in_count = 0;
	int idle_cycles = 0;

	lcg_ranged_random_draw i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.seed_value (seed_value),
		.min_value  (min_value),
		.max_value  (max_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.number     (number),
		.span_error (span_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// order the bounds, step the generator and reduce the raw value
	function automatic draw_result_t predict_draw(input logic signed [WordW-1:0] a,
			input logic signed [WordW-1:0] b);
		logic signed [WordW-1:0] lo;
		logic signed [WordW-1:0] hi;
		logic [WordW-1:0] span;
		logic [WordW-1:0] raw;
		draw_result_t r;
		lo = (b < a) ? b : a;
		hi = (b < a) ? a : b;
		span = hi - lo;
		if (span > SpanMax) begin
			// state untouched on a span error
			r.number = '0;
			r.span_error = 1'b1;
			return r;
		end
		gen_state = gen_state * GenMul + GenAdd;
		raw = {17'b0, gen_state[30:16]};
		if (span == SpanMax) begin
			r.number = lo + raw;
		end else begin
			r.number = lo + (raw % (span + 32'd1));
		end
		r.span_error = 1'b0;
		return r;
	endfunction

	// scoreboard: results are checked before this edge's input is predicted
	always @(posedge clk) begin
		draw_result_t oldest;
		draw_result_t predicted;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_draws.size() == 0) begin
					$error("result with nothing expected: number %0d span_error %0b",
						number, span_error);
					n_errors++;
				end else begin
					oldest = expected_draws.pop_front();
					if (number !== oldest.number) begin
						$error("number mismatch: expected %0d, got %0d", oldest.number, number);
						n_errors++;
					end
					if (span_error !== oldest.span_error) begin
						$error("span_error mismatch: expected %0b, got %0b",
							oldest.span_error, span_error);
						n_errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				in_count <= in_count + 1;
				if (op == OpReseed) begin
					gen_state = seed_value;
				end else begin
					predicted = predict_draw(min_value, max_value);
					if (pin_on) begin
						predicted.number = pin_number;
						predicted.span_error = pin_error;
					end
					expected_draws.push_back(predicted);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// offer one transaction, hold it until taken, then maybe go quiet for a burst
	task automatic send_item(input stim_row_t row, input int idx);
		logic calm;
		in_valid <= 1'b1;
		op <= row.op;
		seed_value <= row.seed;
		min_value <= row.lo_bound;
		max_value <= row.hi_bound;
		pin_on <= row.pinned;
		pin_number <= row.pin_number;
		pin_error <= row.pin_error;
		do @(posedge clk); while (in_stall);
		// calm stretches: periodic windows, around the long hold, and the tail
		calm = ((idx / 64) % 4 == 3) || (idx >= TotalItems - CalmTail) ||
			(idx >= HoldAt - 5 && idx < HoldAt + 30);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// receiver: random stall bursts, one long hold, none near the end
	initial begin
		logic hold_done;
		logic calm;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			calm = ((in_count / 64) % 4 == 1) || (in_count >= TotalItems - CalmTail);
			if (!hold_done && in_count >= HoldAt) begin
				// sender keeps offering, so the block fills up behind this
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HoldCycles - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		while (idle_cycles < IdleLimit) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		stim_row_t row;
		logic [WordW-1:0] base;
		logic [WordW-1:0] width;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DirectedRows; i++) begin
			send_item(DirectedTable[i], i);
		end

		// random part: mostly draws, bounds shaped by span class
		for (int i = 0; i < RandomItems; i++) begin
			row.op = ($urandom_range(0, 6) == 0) ? OpReseed : OpDraw;
			row.seed = $urandom;
			row.pinned = 1'b0;
			row.pin_number = '0;
			row.pin_error = 1'b0;
			base = $urandom;
			case ($urandom_range(0, 9))
				0, 1, 2: width = $urandom_range(0, 40);
				3: width = $urandom_range(0, 100000);
				4: width = $urandom & SpanMax;
				5: width = $urandom;                          // about half too wide
				6: width = '0;
				7: width = 32'h7FFF_FFFE + $urandom_range(0, 2); // around the span limit
				8: width = 32'h0000_7FFE + $urandom_range(0, 4); // around the raw range
				default: begin
					base = $urandom_range(0, 1) ? MinInt : MaxInt;
					width = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
				end
			endcase
			if ($urandom_range(0, 1)) begin
				row.lo_bound = base;
				row.hi_bound = base + width;
			end else begin
				row.lo_bound = base + width;
				row.hi_bound = base;
			end
			send_item(row, DirectedRows + i);
		end
		in_valid <= 1'b0;

		while (expected_draws.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
